// ===== rtl/spa_pkg.sv =====
// shared types and codes of the slot pool allocator
`default_nettype none
package spa_pkg;

  // fixed field widths of the request, response and configuration channels
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 2;

  // request commands
  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REBUILD = 2'd2,
    CMD_CLEAR   = 2'd3
  } spa_cmd_e;

  // response status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_SLOT      = 2'd1,
    STATUS_OUT_OF_POOL  = 2'd2,
    STATUS_ALREADY_FREE = 2'd3
  } spa_status_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_GROWTH  = 2'd2;

  // reset values of the configuration registers
  localparam logic [COUNT_W-1:0] RST_INITIAL_COUNT = 7'd4;
  localparam logic [COUNT_W-1:0] RST_MAX_COUNT     = 7'd64;
  localparam logic               RST_ALLOW_GROWTH  = 1'b1;

  typedef struct packed {
    spa_cmd_e          cmd;
    logic [SLOT_W-1:0] slot_index;
  } spa_req_t;

  typedef struct packed {
    spa_status_e        status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] busy_count;
    logic [COUNT_W-1:0] pool_size;
  } spa_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   wdata;
  } spa_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/spa_stream_if.sv =====
// valid/ready channel interface used for requests, responses and configuration
`default_nettype none
interface spa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/slot_pool_allocator_core.sv =====
// slot pool allocator: fifo free list and busy marks held in two memories
//
// Hands out slot indexes from a pool of up to MAX_SLOTS slots. Free slots sit
// in a fifo memory, in-use marks in a one-bit memory, both with a registered
// read port. One request is worked at a time; the response goes to an
// output register, so the next request is taken while a response waits.
// A growing or failing acquire and an out-of-pool release go straight to
// the response; an acquire from the free list and an in-pool release make
// one memory read, then the write back. Rebuild and clear sweep over
// max(old pool_size, slots to create) places, clearing one busy mark per
// cycle and writing one fifo entry for each slot that they create.
// After reset the block clears all MAX_SLOTS busy marks and takes no
// request until that sweep ends; configuration writes are always taken.
`default_nettype none
module slot_pool_allocator_core
  import spa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  spa_stream_if.sink   cfg_i,
  spa_stream_if.sink   req_i,
  spa_stream_if.source rsp_o
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACQ,
    ST_REL,
    ST_SWEEP,
    ST_RESP
  } state_e;

  // configuration registers
  logic [COUNT_W-1:0] init_count_q;
  logic [COUNT_W-1:0] max_count_q;
  logic               allow_growth_q;

  // control state
  state_e             state_q;
  logic [IW-1:0]      head_q;
  logic [IW-1:0]      tail_q;
  logic [CW-1:0]      fill_q;
  logic [CW-1:0]      busy_q;
  logic [CW-1:0]      total_q;
  logic [CW-1:0]      sweep_cnt_q;
  logic [CW-1:0]      sweep_end_q;
  logic [CW-1:0]      sweep_n_q;
  logic               sweep_rsp_q;
  logic               rsp_valid_q;

  // payload registers
  logic [SLOT_W-1:0]  idx_q;
  spa_status_e        res_status_q;
  logic [IW-1:0]      res_granted_q;
  spa_rsp_t           rsp_q;

  // memories
  logic [IW-1:0]      fifo_mem [MAX_SLOTS];
  logic               busy_mem [MAX_SLOTS];
  logic [IW-1:0]      fifo_rdata_q;
  logic               busy_rdata_q;

  // memory port controls
  logic               fifo_re;
  logic [IW-1:0]      fifo_raddr;
  logic               fifo_we;
  logic [IW-1:0]      fifo_waddr;
  logic [IW-1:0]      fifo_wdata;
  logic               busy_re;
  logic [IW-1:0]      busy_raddr;
  logic               busy_we;
  logic [IW-1:0]      busy_waddr;
  logic               busy_wdata;

  // request decode
  logic               req_acc;
  logic               can_grow;
  logic               out_of_pool;
  logic [WW-1:0]      rebuild_ww;
  logic [CW-1:0]      rebuild_n;
  logic [CW-1:0]      new_n;
  logic [CW-1:0]      new_end;
  logic [IW-1:0]      new_tail;
  logic               rsp_free;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  // growth needs a free pool place below both limits
  assign can_grow = allow_growth_q
                    && (WW'(total_q) < WW'(max_count_q))
                    && (total_q != CW'(MAX_SLOTS));

  assign out_of_pool = WW'(req_i.data.slot_index) >= WW'(total_q);

  // slots created by rebuild, saturated to the capacity
  assign rebuild_ww = (WW'(init_count_q) < WW'(MAX_SLOTS)) ? WW'(init_count_q)
                                                           : WW'(MAX_SLOTS);
  assign rebuild_n  = CW'(rebuild_ww);
  assign new_n      = (req_i.data.cmd == CMD_REBUILD) ? rebuild_n : '0;
  assign new_end    = (total_q > new_n) ? total_q : new_n;
  assign new_tail   = (new_n == CW'(MAX_SLOTS)) ? '0 : IW'(new_n);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count_q   <= RST_INITIAL_COUNT;
      max_count_q    <= RST_MAX_COUNT;
      allow_growth_q <= RST_ALLOW_GROWTH;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        CFG_INITIAL_COUNT: init_count_q   <= cfg_i.data.wdata;
        CFG_MAX_COUNT:     max_count_q    <= cfg_i.data.wdata;
        CFG_ALLOW_GROWTH:  allow_growth_q <= cfg_i.data.wdata[0];
        default:           ;
      endcase
    end
  end

  // memory port selection per state
  always_comb begin
    fifo_re    = 1'b0;
    fifo_raddr = head_q;
    fifo_we    = 1'b0;
    fifo_waddr = tail_q;
    fifo_wdata = IW'(idx_q);
    busy_re    = 1'b0;
    busy_raddr = IW'(req_i.data.slot_index);
    busy_we    = 1'b0;
    busy_waddr = IW'(total_q);
    busy_wdata = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_i.data.cmd)
            CMD_ACQUIRE: begin
              if (fill_q != '0) begin
                fifo_re = 1'b1;
              end else if (can_grow) begin
                busy_we    = 1'b1;
                busy_wdata = 1'b1;
              end
            end
            CMD_RELEASE: begin
              busy_re = !out_of_pool;
            end
            default: ;
          endcase
        end
      end
      ST_ACQ: begin
        busy_we    = 1'b1;
        busy_waddr = fifo_rdata_q;
        busy_wdata = 1'b1;
      end
      ST_REL: begin
        if (busy_rdata_q) begin
          busy_we    = 1'b1;
          busy_waddr = IW'(idx_q);
          fifo_we    = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt_q != sweep_end_q) begin
          busy_we    = 1'b1;
          busy_waddr = IW'(sweep_cnt_q);
          if (sweep_cnt_q < sweep_n_q) begin
            fifo_we    = 1'b1;
            fifo_waddr = IW'(sweep_cnt_q);
            fifo_wdata = IW'(sweep_cnt_q);
          end
        end
      end
      default: ;
    endcase
  end

  // free list memory
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (fifo_re) begin
      fifo_rdata_q <= fifo_mem[fifo_raddr];
    end
  end

  // busy mark memory
  always_ff @(posedge clk_i) begin
    if (busy_we) begin
      busy_mem[busy_waddr] <= busy_wdata;
    end
    if (busy_re) begin
      busy_rdata_q <= busy_mem[busy_raddr];
    end
  end

  // request sequencer and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      busy_q        <= '0;
      total_q       <= '0;
      sweep_cnt_q   <= '0;
      sweep_end_q   <= CW'(MAX_SLOTS);
      sweep_n_q     <= '0;
      sweep_rsp_q   <= 1'b0;
      rsp_valid_q   <= 1'b0;
      idx_q         <= '0;
      res_status_q  <= STATUS_OK;
      res_granted_q <= '0;
      rsp_q         <= '0;
    end else begin
      // response taken and no new one loaded this cycle
      if (rsp_valid_q && rsp_o.ready && (state_q != ST_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            idx_q <= req_i.data.slot_index;
            case (req_i.data.cmd)
              CMD_ACQUIRE: begin
                if (fill_q != '0) begin
                  res_status_q <= STATUS_OK;
                  state_q      <= ST_ACQ;
                end else if (can_grow) begin
                  res_status_q  <= STATUS_OK;
                  res_granted_q <= IW'(total_q);
                  total_q       <= total_q + CW'(1);
                  busy_q        <= busy_q + CW'(1);
                  state_q       <= ST_RESP;
                end else begin
                  res_status_q  <= STATUS_NO_SLOT;
                  res_granted_q <= '0;
                  state_q       <= ST_RESP;
                end
              end
              CMD_RELEASE: begin
                res_granted_q <= '0;
                if (out_of_pool) begin
                  res_status_q <= STATUS_OUT_OF_POOL;
                  state_q      <= ST_RESP;
                end else begin
                  state_q <= ST_REL;
                end
              end
              default: begin
                // rebuild and clear restart the pool, then sweep the memories
                res_status_q  <= STATUS_OK;
                res_granted_q <= '0;
                head_q        <= '0;
                tail_q        <= new_tail;
                fill_q        <= new_n;
                busy_q        <= '0;
                total_q       <= new_n;
                sweep_cnt_q   <= '0;
                sweep_end_q   <= new_end;
                sweep_n_q     <= new_n;
                sweep_rsp_q   <= 1'b1;
                state_q       <= ST_SWEEP;
              end
            endcase
          end
        end
        ST_ACQ: begin
          res_granted_q <= fifo_rdata_q;
          head_q        <= (head_q == IW'(MAX_SLOTS - 1)) ? '0 : head_q + IW'(1);
          fill_q        <= fill_q - CW'(1);
          busy_q        <= busy_q + CW'(1);
          state_q       <= ST_RESP;
        end
        ST_REL: begin
          if (busy_rdata_q) begin
            res_status_q <= STATUS_OK;
            tail_q <= (tail_q == IW'(MAX_SLOTS - 1)) ? '0 : tail_q + IW'(1);
            fill_q <= fill_q + CW'(1);
            busy_q <= busy_q - CW'(1);
          end else begin
            res_status_q <= STATUS_ALREADY_FREE;
          end
          state_q <= ST_RESP;
        end
        ST_SWEEP: begin
          if (sweep_cnt_q == sweep_end_q) begin
            state_q <= sweep_rsp_q ? ST_RESP : ST_IDLE;
          end else begin
            sweep_cnt_q <= sweep_cnt_q + CW'(1);
          end
        end
        ST_RESP: begin
          if (rsp_free) begin
            rsp_valid_q        <= 1'b1;
            rsp_q.status       <= res_status_q;
            rsp_q.granted_slot <= SLOT_W'(res_granted_q);
            rsp_q.free_count   <= COUNT_W'(fill_q);
            rsp_q.busy_count   <= COUNT_W'(busy_q);
            rsp_q.pool_size    <= COUNT_W'(total_q);
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spa_checker.sv =====
// port-level assertions for the slot pool allocator and their bind
`default_nettype none
module spa_checker
  import spa_pkg::*;
(
  input wire               clk_i,
  input wire               rst_ni,
  input wire               req_valid_i,
  input wire               req_ready_i,
  input wire               rsp_valid_i,
  input wire               rsp_ready_i,
  input wire [1:0]         rsp_status_i,
  input wire [SLOT_W-1:0]  rsp_granted_i,
  input wire [COUNT_W-1:0] rsp_free_i,
  input wire [COUNT_W-1:0] rsp_busy_i,
  input wire [COUNT_W-1:0] rsp_pool_i
);

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i
      && $stable(rsp_status_i) && $stable(rsp_granted_i)
      && $stable(rsp_free_i) && $stable(rsp_busy_i) && $stable(rsp_pool_i))
    else $error("response changed while stalled");

  // one request in work at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another one is in work");

  // every pool slot is either free or in use
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> COUNT_W'(rsp_free_i + rsp_busy_i) == rsp_pool_i)
    else $error("free and busy counts do not add up to the pool size");

  // failed requests grant nothing, and no-slot means an empty free list
  a_fail_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |-> rsp_granted_i == '0
      && ((rsp_status_i != STATUS_NO_SLOT) || (rsp_free_i == '0)))
    else $error("failed request reports a slot or free slots");

endmodule

bind slot_pool_allocator_core spa_checker u_spa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.data.status),
  .rsp_granted_i (rsp_o.data.granted_slot),
  .rsp_free_i    (rsp_o.data.free_count),
  .rsp_busy_i    (rsp_o.data.busy_count),
  .rsp_pool_i    (rsp_o.data.pool_size)
);
`default_nettype wire
